### rtl/direct_mapped_writeback_cache_core_assert.svh
// Assertion macros shared by the cache RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_CORE_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DMWBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dmwbc: assertion failed");
`define DMWBC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("dmwbc: assertion failed during or after reset");
`else
`define DMWBC_ASSERT(lbl, prop)
`define DMWBC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/dmwbc_pkg.sv
// Shared types and constants for the direct-mapped write-back cache.
// No dependencies; used by every module of the block except dmwbc_ram.
`timescale 1ns / 1ps
package dmwbc_pkg;

  localparam int ADDR_W = 11;
  localparam int DATA_W = 8;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WB,
    ST_FILL,
    ST_ACCESS,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // back end to front end control
  typedef struct packed {
    logic pop;
    logic init_busy;
  } ctrl_t;

endpackage

### rtl/dmwbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module dmwbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, hold data while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dmwbc_front.sv
// Front end: accepts access beats into a two-entry queue for the back end.
// Depends on dmwbc_pkg.
`timescale 1ns / 1ps
module dmwbc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dmwbc_pkg::item_t in_item_i,
  input  dmwbc_pkg::ctrl_t ctrl_i,
  output dmwbc_pkg::head_t head_o
);
  import dmwbc_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);
  localparam logic [CNT_W-1:0] QFULL = CNT_W'(QDEPTH);

  item_t            entries_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  // hold off new beats while full or while memory is being initialised
  assign in_stall_o = (count_q == QFULL) || ctrl_i.init_busy;
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = ctrl_i.pop && (count_q != '0);

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // store accepted beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= in_item_i;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = entries_q[rd_ptr_q];

endmodule

### rtl/dmwbc_back.sv
// Back end: tag lookup, write-back, line fill, byte access and result register.
// Depends on dmwbc_pkg, dmwbc_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "direct_mapped_writeback_cache_core_assert.svh"
module dmwbc_back #(
  parameter int NUM_LINES  = 16,
  parameter int LINE_BYTES = 16,
  parameter int MEM_BYTES  = 2048
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dmwbc_pkg::head_t               head_i,
  output dmwbc_pkg::ctrl_t               ctrl_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dmwbc_pkg::DATA_W-1:0]   read_data_o,
  output logic                           hit_o
);
  import dmwbc_pkg::*;

  localparam int OFF_W   = $clog2(LINE_BYTES);
  localparam int IDX_W   = $clog2(NUM_LINES);
  localparam int MEM_AW  = $clog2(MEM_BYTES);
  localparam int TAG_RAW = MEM_AW - IDX_W - OFF_W;
  localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int LINE_AW = IDX_W + OFF_W;
  localparam int CAT_W   = TAG_W + LINE_AW;
  localparam int EXT_W   = ADDR_W + MEM_AW;
  localparam logic [OFF_W:0]    LB_CNT    = (OFF_W + 1)'(LINE_BYTES);
  localparam logic [MEM_AW-1:0] INIT_LAST = MEM_AW'(MEM_BYTES - 1);

  state_e state_q, state_d;

  logic [OFF_W:0]      cnt_q, cnt_d;
  logic [MEM_AW-1:0]   init_cnt_q, init_cnt_d;
  logic                pend_q, pend_d;
  logic [OFF_W-1:0]    pend_off_q, pend_off_d;

  logic                line_valid_q [NUM_LINES];
  logic                line_dirty_q [NUM_LINES];
  logic [TAG_W-1:0]    line_tag_q   [NUM_LINES];

  op_e                 job_op_q;
  logic [IDX_W-1:0]    job_idx_q;
  logic [TAG_W-1:0]    job_tag_q;
  logic [OFF_W-1:0]    job_off_q;
  logic [DATA_W-1:0]   job_wdata_q;
  logic                job_hit_q;

  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_data_q;
  logic                out_hit_q;

  logic                take_job;
  logic                fill_done;
  logic                mark_dirty;
  logic                out_load;

  // head address split
  logic [EXT_W-1:0]    head_ext;
  logic [MEM_AW-1:0]   head_addr;
  logic [MEM_AW-1:0]   head_tag_full;
  logic [MEM_AW-1:0]   head_idx_full;
  logic [TAG_W-1:0]    head_tag;
  logic [IDX_W-1:0]    head_idx;
  logic [OFF_W-1:0]    head_off;
  logic                head_hit;

  logic [CAT_W-1:0]    vict_cat;
  logic [CAT_W-1:0]    fill_cat;

  // line store and backing memory ports
  logic                line_we, line_re;
  logic [LINE_AW-1:0]  line_waddr, line_raddr;
  logic [DATA_W-1:0]   line_wdata, line_rdata;
  logic                mem_we, mem_re;
  logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
  logic [DATA_W-1:0]   mem_wdata, mem_rdata;

  dmwbc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_LINES * LINE_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .re_i    (line_re),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  dmwbc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_BYTES)
  ) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // wrap address into memory, then split into tag, index and offset
  assign head_ext      = {{MEM_AW{1'b0}}, head_i.item.address};
  assign head_addr     = head_ext[MEM_AW-1:0];
  assign head_tag_full = head_addr >> LINE_AW;
  assign head_idx_full = head_addr >> OFF_W;
  assign head_tag      = head_tag_full[TAG_W-1:0];
  assign head_idx      = head_idx_full[IDX_W-1:0];
  assign head_off      = head_addr[OFF_W-1:0];
  assign head_hit      = line_valid_q[head_idx] && (line_tag_q[head_idx] == head_tag);

  // block addresses for write-back and fill
  assign vict_cat = {line_tag_q[job_idx_q], job_idx_q, pend_off_q};
  assign fill_cat = {job_tag_q, job_idx_q, cnt_q[OFF_W-1:0]};

  // sequencer: next state, memory strobes and result handover
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    init_cnt_d  = init_cnt_q;
    pend_d      = 1'b0;
    pend_off_d  = cnt_q[OFF_W-1:0];
    take_job    = 1'b0;
    fill_done   = 1'b0;
    mark_dirty  = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    line_we     = 1'b0;
    line_re     = 1'b0;
    line_waddr  = {job_idx_q, job_off_q};
    line_raddr  = {job_idx_q, job_off_q};
    line_wdata  = job_wdata_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = vict_cat[MEM_AW-1:0];
    mem_raddr   = fill_cat[MEM_AW-1:0];
    mem_wdata   = line_rdata;
    case (state_q)
      ST_INIT: begin
        // fill memory with the low address byte
        mem_we    = 1'b1;
        mem_waddr = init_cnt_q;
        mem_wdata = init_cnt_q[DATA_W-1:0];
        if (init_cnt_q == INIT_LAST) begin
          state_d = ST_IDLE;
        end else begin
          init_cnt_d = init_cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (head_i.valid) begin
          take_job = 1'b1;
          cnt_d    = '0;
          if (head_hit) begin
            state_d = ST_ACCESS;
          end else if (line_dirty_q[head_idx]) begin
            state_d = ST_WB;
          end else begin
            state_d = ST_FILL;
          end
        end
      end
      ST_WB: begin
        // read victim bytes, write each to memory in the cycle after its read
        if (cnt_q != LB_CNT) begin
          line_re    = 1'b1;
          line_raddr = {job_idx_q, cnt_q[OFF_W-1:0]};
          pend_d     = 1'b1;
          cnt_d      = cnt_q + 1'b1;
        end else begin
          state_d = ST_FILL;
          cnt_d   = '0;
        end
        mem_we = pend_q;
      end
      ST_FILL: begin
        // read block bytes, write each into the line in the cycle after its read
        if (cnt_q != LB_CNT) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end else begin
          fill_done = 1'b1;
          state_d   = ST_ACCESS;
        end
        line_we    = pend_q;
        line_waddr = {job_idx_q, pend_off_q};
        line_wdata = mem_rdata;
      end
      ST_ACCESS: begin
        if (job_op_q == OP_WRITE) begin
          line_we    = 1'b1;
          mark_dirty = 1'b1;
        end else begin
          line_re = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hand over once the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_load    = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      init_cnt_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      init_cnt_q  <= init_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // line state: valid, dirty and tag per line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        line_valid_q[i] <= 1'b0;
        line_dirty_q[i] <= 1'b0;
        line_tag_q[i]   <= '0;
      end
    end else begin
      if (fill_done) begin
        line_valid_q[job_idx_q] <= 1'b1;
        line_dirty_q[job_idx_q] <= 1'b0;
        line_tag_q[job_idx_q]   <= job_tag_q;
      end
      if (mark_dirty) begin
        line_dirty_q[job_idx_q] <= 1'b1;
      end
    end
  end

  // job and result payload
  always_ff @(posedge clk_i) begin
    pend_off_q <= pend_off_d;
    if (take_job) begin
      job_op_q    <= head_i.item.op;
      job_idx_q   <= head_idx;
      job_tag_q   <= head_tag;
      job_off_q   <= head_off;
      job_wdata_q <= head_i.item.write_data;
      job_hit_q   <= head_hit;
    end
    if (out_load) begin
      out_data_q <= (job_op_q == OP_WRITE) ? job_wdata_q : line_rdata;
      out_hit_q  <= job_hit_q;
    end
  end

  assign ctrl_o.pop       = take_job;
  assign ctrl_o.init_busy = (state_q == ST_INIT);
  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_data_q;
  assign hit_o            = out_hit_q;

  `DMWBC_ASSERT(a_fill_installs_line, (state_q == ST_FILL && cnt_q == LB_CNT) |=> (line_valid_q[job_idx_q] && line_tag_q[job_idx_q] == job_tag_q))
  `DMWBC_ASSERT(a_access_on_resident_line, (state_q == ST_ACCESS) |-> (line_valid_q[job_idx_q] && line_tag_q[job_idx_q] == job_tag_q))
  `DMWBC_ASSERT(a_write_leaves_dirty, (state_q == ST_DONE && job_op_q == OP_WRITE) |-> line_dirty_q[job_idx_q])
  `DMWBC_ASSERT(a_mem_write_source, mem_we |-> (state_q == ST_INIT || state_q == ST_WB))
  `DMWBC_ASSERT_ALWAYS(a_no_result_during_init, (state_q == ST_INIT) |-> !out_valid_q)

endmodule

### rtl/direct_mapped_writeback_cache_core.sv
// Direct-mapped write-back, write-allocate byte cache in front of a byte-wide memory.
// Input channel: in_valid_i / in_stall_o carry op_i, address_i and write_data_i.
// Output channel: out_valid_o / out_stall_i carry read_data_o and hit_o, one
// result beat per input beat, in order. A read returns the addressed byte, a
// write returns the byte just stored; hit_o reports the lookup before the access.
// Each item passes through lookup, line access and result load on a hit; a miss
// first fills the line byte by byte, and a dirty victim is written back before
// the fill. The single byte-wide memory port sets the miss cost.
// A two-entry input queue lets the sender run ahead while the back end works,
// and the result register frees the back end while a result waits.
// After reset the backing memory is written with the low byte of each address,
// one byte a cycle, over all MEM_BYTES addresses; in_stall_o stays high meanwhile and
// all lines start invalid. While out_stall_i is high the result holds and the
// back end waits in its last step; the queue keeps taking beats until full.
// Parameters must be powers of two.
`timescale 1ns / 1ps
module direct_mapped_writeback_cache_core #(
  parameter int NUM_LINES  = 16,
  parameter int LINE_BYTES = 16,
  parameter int MEM_BYTES  = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [dmwbc_pkg::ADDR_W-1:0]  address_i,
  input  logic [dmwbc_pkg::DATA_W-1:0]  write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dmwbc_pkg::DATA_W-1:0]  read_data_o,
  output logic                          hit_o
);
  import dmwbc_pkg::*;

  item_t in_item;
  head_t head;
  ctrl_t ctrl;

  // pack the input beat
  assign in_item.op         = op_e'(op_i);
  assign in_item.address    = address_i;
  assign in_item.write_data = write_data_i;

  dmwbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .ctrl_i     (ctrl),
    .head_o     (head)
  );

  dmwbc_back #(
    .NUM_LINES  (NUM_LINES),
    .LINE_BYTES (LINE_BYTES),
    .MEM_BYTES  (MEM_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .ctrl_o      (ctrl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .hit_o       (hit_o)
  );

endmodule

### test/tb_top.sv
// Self-checking bench for direct_mapped_writeback_cache_core: a clocked driver and
// monitor around a cycle-free model of the tag store, line store and backing memory.
// Depends on dmwbc_pkg for the access opcodes and the port widths.
`timescale 1ns / 1ps
module tb_top;
  import dmwbc_pkg::*;

  localparam int NUM_LINES  = 16;
  localparam int LINE_BYTES = 16;
  localparam int MEM_BYTES  = 2048;
  localparam int OFF_W      = $clog2(LINE_BYTES);
  localparam int IDX_W      = $clog2(NUM_LINES);
  localparam int TAG_W      = ADDR_W - OFF_W - IDX_W;
  localparam int RANDOM_ACCESSES = 1000;
  localparam int QUIET_TAIL      = 150;
  localparam int CYCLE_LIMIT     = 300000;

  typedef struct {
    op_e               op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    bit                drain;   // hold this access until every result is back
  } access_t;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic              hit;
  } lookup_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                op_i = 1'b0;
  logic [ADDR_W-1:0]   address_i = '0;
  logic [DATA_W-1:0]   write_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [DATA_W-1:0]   read_data_o;
  logic                hit_o;

  // cache state as the block should hold it
  logic                line_ok   [NUM_LINES];
  logic                line_mod  [NUM_LINES];
  logic [TAG_W-1:0]    line_owner[NUM_LINES];
  logic [DATA_W-1:0]   line_store[NUM_LINES*LINE_BYTES];
  logic [DATA_W-1:0]   home_mem  [MEM_BYTES];

  access_t pending_accesses[$];
  lookup_t lookups_due[$];
  int      accepted_cnt = 0;
  int      returned_cnt = 0;
  int      idle_left = 0;
  int      stall_left = 0;
  int      cycle_cnt = 0;
  int      error_cnt = 0;
  logic    quiet = 1'b0;

  direct_mapped_writeback_cache_core #(
    .NUM_LINES (NUM_LINES),
    .LINE_BYTES(LINE_BYTES),
    .MEM_BYTES (MEM_BYTES)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .address_i   (address_i),
    .write_data_i(write_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .hit_o       (hit_o)
  );

  always #1 clk_i = ~clk_i;

  // Look up one byte access, write back a dirty victim and refill on a miss, and return the byte
  // the block should report together with its hit flag.
  function automatic lookup_t cache_lookup(input access_t acc);
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] off;
    logic [TAG_W-1:0] tag;
    lookup_t          res;
    int               k;
    idx = acc.address[OFF_W +: IDX_W];
    off = acc.address[OFF_W-1:0];
    tag = acc.address[ADDR_W-1 -: TAG_W];
    res.hit = line_ok[idx] && (line_owner[idx] == tag);
    if (!res.hit) begin
      if (line_mod[idx]) begin
        for (k = 0; k < LINE_BYTES; k++)
          home_mem[{line_owner[idx], idx, k[OFF_W-1:0]}] = line_store[{idx, k[OFF_W-1:0]}];
      end
      for (k = 0; k < LINE_BYTES; k++)
        line_store[{idx, k[OFF_W-1:0]}] = home_mem[{tag, idx, k[OFF_W-1:0]}];
      line_ok[idx]    = 1'b1;
      line_mod[idx]   = 1'b0;
      line_owner[idx] = tag;
    end
    if (acc.op == OP_WRITE) begin
      line_store[{idx, off}] = acc.write_data;
      line_mod[idx]          = 1'b1;
      res.read_data          = acc.write_data;
    end else begin
      res.read_data = line_store[{idx, off}];
    end
    return res;
  endfunction

  function automatic access_t make_access(input op_e op, input int addr, input int data,
                                          input bit drain);
    access_t acc;
    acc.op         = op;
    acc.address    = addr[ADDR_W-1:0];
    acc.write_data = data[DATA_W-1:0];
    acc.drain      = drain;
    return acc;
  endfunction

  // Drive input beats: predict on acceptance, then either idle or present the next access.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      op_i         <= 1'b0;
      address_i    <= '0;
      write_data_i <= '0;
      quiet        <= 1'b0;
    end else begin : drive
      bit      taken;
      int      in_flight;
      access_t nxt;
      taken = in_valid_i && !in_stall_o;
      in_flight = accepted_cnt - returned_cnt;
      if (taken) begin
        lookups_due.push_back(cache_lookup(pending_accesses.pop_front()));
        accepted_cnt <= accepted_cnt + 1;
        in_flight++;
        if (!quiet && ((accepted_cnt / 64) % 3 != 2) && $urandom_range(0, 3) == 0)
          idle_left = $urandom_range(1, 8);
      end
      quiet <= (pending_accesses.size() <= QUIET_TAIL);
      if (!in_valid_i || taken) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid_i <= 1'b0;
        end else if (pending_accesses.size() > 0 &&
                     (!pending_accesses[0].drain || in_flight == 0)) begin
          nxt = pending_accesses[0];
          in_valid_i   <= 1'b1;
          op_i         <= nxt.op;
          address_i    <= nxt.address;
          write_data_i <= nxt.write_data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check result beats against the oldest prediction and throttle the output side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin : watch
      lookup_t want;
      if (out_valid_o && !out_stall_i) begin
        returned_cnt <= returned_cnt + 1;
        if (lookups_due.size() == 0) begin
          $error("unexpected result beat: read_data=%0h hit=%0b", read_data_o, hit_o);
          error_cnt++;
        end else begin
          want = lookups_due.pop_front();
          if (read_data_o !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, read_data_o);
            error_cnt++;
          end
          if (hit_o !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, hit_o);
            error_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && ((returned_cnt / 64) % 3 != 1) && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Give up on a hung block.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int      n;
    int      tag;
    int      idx;
    int      addr;
    op_e     op;
    for (n = 0; n < NUM_LINES; n++) begin
      line_ok[n]    = 1'b0;
      line_mod[n]   = 1'b0;
      line_owner[n] = '0;
    end
    for (n = 0; n < NUM_LINES * LINE_BYTES; n++) line_store[n] = '0;
    for (n = 0; n < MEM_BYTES; n++) home_mem[n] = n[DATA_W-1:0];

    // cold miss, hit, dirty victims in both directions, extremes of address and data
    pending_accesses.push_back(make_access(OP_READ,  'h000, 'h00, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h00F, 'hFF, 1'b0));
    pending_accesses.push_back(make_access(OP_WRITE, 'h005, 'hFF, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h005, 'h00, 1'b0));
    pending_accesses.push_back(make_access(OP_WRITE, 'h105, 'h00, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h000, 'h00, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h005, 'h00, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h7FF, 'h00, 1'b0));
    pending_accesses.push_back(make_access(OP_WRITE, 'h7F0, 'hA5, 1'b0));
    pending_accesses.push_back(make_access(OP_WRITE, 'h3F3, 'h5A, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h7F0, 'h00, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h3F3, 'h00, 1'b0));
    pending_accesses.push_back(make_access(OP_WRITE, 'h280, 'h81, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h080, 'h00, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h280, 'h00, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h105, 'h00, 1'b1));
    pending_accesses.push_back(make_access(OP_WRITE, 'h555, 'h3C, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h2AA, 'hC3, 1'b0));
    pending_accesses.push_back(make_access(OP_WRITE, 'h2AA, 'h00, 1'b0));
    pending_accesses.push_back(make_access(OP_READ,  'h555, 'h00, 1'b0));

    // mostly a few tags on a few lines so that hits, conflicts and write-backs recur
    for (n = 0; n < RANDOM_ACCESSES; n++) begin
      op = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
      if ($urandom_range(0, 9) < 7) begin
        tag  = $urandom_range(0, 2);
        idx  = $urandom_range(0, 3);
        addr = (tag << (IDX_W + OFF_W)) | (idx << OFF_W) | $urandom_range(0, LINE_BYTES - 1);
      end else begin
        addr = $urandom_range(0, MEM_BYTES - 1);
      end
      pending_accesses.push_back(make_access(op, addr, $urandom_range(0, 255),
                                             (n % 250) == 249));
    end

    // hold reset, then release it
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the last beat, the last result, then let any stray beat show
    do @(posedge clk_i);
    while (pending_accesses.size() > 0 || in_valid_i || accepted_cnt != returned_cnt);
    repeat (64) @(posedge clk_i);
    if (error_cnt == 0 && lookups_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
